FILE: rtl/fsa_pkg.sv
// Shared types, widths and codes of the frame stack accumulator.
package fsa_pkg;

	localparam int PIXELS  = 1024;
	localparam int BINS    = 256;
	localparam int PIX_W   = $clog2(PIXELS);
	localparam int BIN_W   = $clog2(BINS);
	localparam int HADDR_W = PIX_W + BIN_W;
	localparam int ACC_W   = 18;
	localparam int CNT_W   = 9;
	localparam int CUM_W   = 17;
	localparam int DIVD_W  = 28;
	localparam int MAG_W   = 27;
	localparam int DIVS_W  = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(BINS - 2);
	localparam logic [BIN_W-1:0] FINAL_BIN = BIN_W'(BINS - 1);

	// Item commands.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ACC   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Readout methods.
	localparam logic [1:0] METH_SUM = 2'd0;
	localparam logic [1:0] METH_AVG = 2'd1;
	localparam logic [1:0] METH_MED = 2'd2;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_METHOD = 3'd0;
	localparam logic [IDX_W-1:0] REG_LOW    = 3'd1;
	localparam logic [IDX_W-1:0] REG_HIGH   = 3'd2;
	localparam logic [IDX_W-1:0] REG_SCALE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_NEGATE = 3'd4;

	// Divider request and response.
	typedef struct packed {
		logic                     start;
		logic signed [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/frame_stack_accumulator.sv
// Top level of the per-pixel frame stacker: control, memories and readout.
// Each word is done before the next is taken. An accumulate rewrites the running sum;
// a histogram accumulate decrements the dropped bin, if any, and increments the new one.
// Clear sweeps the pixel's 256 histogram bins. A sum or average read takes its result
// from the divider, bar an average of zero frames; a median read walks the bins in turn.
// After reset a clearing pass zeroes both memories; no word is taken.
module frame_stack_accumulator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fsa_pkg::IDX_W-1:0]    cfg_index,
	input  logic [fsa_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [1:0]                   cmd,
	input  logic [fsa_pkg::PIX_W-1:0]    pixel_index,
	input  logic                         is_chroma,
	input  logic [7:0]                   new_sample,
	input  logic [7:0]                   old_sample,
	input  logic                         drop_old,
	input  logic [8:0]                   frames_stacked,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [7:0]                   out_pixel,
	output logic                         valid_res
);
	import fsa_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLR, S_ACC_WR, S_HO_WR, S_HN_WR,
		S_RD_WAIT, S_DIV, S_MED_RD, S_MED_CHK, S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [1:0]       method_q;
	logic [CFG_W-1:0] low_q, high_q, scale_q;
	logic             negate_q;

	// Latched word.
	logic [PIX_W-1:0] pix_q;
	logic             chroma_q;
	logic [7:0]       ns_q, os_q;
	logic [8:0]       frames_q;
	logic             fwd_q;
	logic [CNT_W-1:0] dec_q;

	logic [HADDR_W-1:0] init_q;
	logic [BIN_W-1:0]   bin_q;
	logic [CUM_W-1:0]   cum_q;
	logic [7:0]         y_q;
	logic               vres_q;
	logic               res_valid_q;
	logic [7:0]         out_pixel_q;
	logic               valid_res_q;

	// Memory ports.
	logic               acc_we;
	logic [PIX_W-1:0]   acc_waddr, acc_raddr;
	logic [ACC_W-1:0]   acc_wdata, acc_rdata;
	logic               hist_we;
	logic [HADDR_W-1:0] hist_waddr, hist_raddr;
	logic [CNT_W-1:0]   hist_wdata, hist_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic accept;
	logic slot_free;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign slot_free  = !res_valid_q || res_ready;

	fsa_ram #(.ADDR_W(PIX_W), .DATA_W(ACC_W)) u_acc_ram (
		.clk  (clk),
		.we   (acc_we),
		.waddr(acc_waddr),
		.wdata(acc_wdata),
		.raddr(acc_raddr),
		.rdata(acc_rdata)
	);

	fsa_ram #(.ADDR_W(HADDR_W), .DATA_W(CNT_W)) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	fsa_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Running sum update with chroma bias.
	logic [ACC_W-1:0] bias, acc_new;
	assign bias    = chroma_q ? ACC_W'(128) : '0;
	assign acc_new = (fwd_q ? acc_rdata - ACC_W'(os_q) + bias : acc_rdata)
		+ ACC_W'(ns_q) - bias;

	// Histogram increment with forwarding when both bins coincide.
	logic [CNT_W-1:0] inc_base;
	assign inc_base = fwd_q ? dec_q : hist_rdata;

	// Accumulator memory access.
	always_comb begin
		acc_raddr = (state_q == S_IDLE) ? pixel_index : pix_q;
		acc_we    = 1'b0;
		acc_waddr = pix_q;
		acc_wdata = '0;
		unique case (state_q)
			S_INIT: begin
				acc_we    = 1'b1;
				acc_waddr = init_q[HADDR_W-1:BIN_W];
			end
			S_IDLE: begin
				acc_we    = accept && (cmd == CMD_CLEAR);
				acc_waddr = pixel_index;
			end
			S_ACC_WR: begin
				acc_we    = 1'b1;
				acc_wdata = acc_new;
			end
			default: acc_we = 1'b0;
		endcase
	end

	// Histogram memory access.
	always_comb begin
		hist_raddr = {pix_q, bin_q};
		hist_we    = 1'b0;
		hist_waddr = {pix_q, bin_q};
		hist_wdata = '0;
		unique case (state_q)
			S_INIT: begin
				hist_we    = 1'b1;
				hist_waddr = init_q;
			end
			S_IDLE: hist_raddr = {pixel_index, drop_old ? old_sample : new_sample};
			S_CLR: hist_we = 1'b1;
			S_HO_WR: begin
				hist_raddr = {pix_q, ns_q};
				hist_we    = 1'b1;
				hist_waddr = {pix_q, os_q};
				hist_wdata = hist_rdata - 1'b1;
			end
			S_HN_WR: begin
				hist_we    = 1'b1;
				hist_waddr = {pix_q, ns_q};
				hist_wdata = inc_base + 1'b1;
			end
			default: hist_we = 1'b0;
		endcase
	end

	// Divider operands for the three readout kinds.
	logic signed [ACC_W:0]    diff;
	logic signed [DIVD_W-1:0] luma_num, chroma_num, avg_num;
	logic signed [CFG_W:0]    interval;
	logic [DIVS_W-1:0]        intv, scl;
	assign diff       = $signed({acc_rdata[ACC_W-1], acc_rdata}) - $signed({3'b0, low_q});
	assign luma_num   = (DIVD_W'(diff) <<< 8) - DIVD_W'(diff);
	assign chroma_num = DIVD_W'($signed(acc_rdata)) <<< 7;
	assign avg_num    = DIVD_W'($signed(acc_rdata));
	assign interval   = $signed({1'b0, high_q}) - $signed({1'b0, low_q});
	assign intv       = (interval <= 0) ? DIVS_W'(1) : interval[DIVS_W-1:0];
	assign scl        = (scale_q == '0) ? DIVS_W'(1) : scale_q;

	always_comb begin
		div_req.start    = (state_q == S_RD_WAIT) && (method_q != METH_MED)
			&& !((method_q == METH_AVG) && (frames_q == '0));
		div_req.dividend = luma_num;
		div_req.divisor  = intv;
		if (method_q == METH_AVG) begin
			div_req.dividend = avg_num;
			div_req.divisor  = DIVS_W'(frames_q);
		end else if (chroma_q) begin
			div_req.dividend = chroma_num;
			div_req.divisor  = scl;
		end
	end

	// Final conversion of the quotient.
	logic signed [DIVD_W:0] avg_v;
	logic [7:0]             y_fin, y_clamp;
	assign avg_v = DIVD_W'(div_rsp.quotient) + (chroma_q ? 29'sd128 : 29'sd0);
	always_comb begin
		if (method_q == METH_AVG) begin
			y_fin = (avg_v <= 0) ? 8'd0 : (avg_v >= 255) ? 8'd255 : avg_v[7:0];
			y_clamp = y_fin;
		end else if (chroma_q) begin
			y_fin = (div_rsp.quotient <= -128) ? 8'd0
				: (div_rsp.quotient >= 127) ? 8'd255 : 8'(div_rsp.quotient + 128);
			y_clamp = y_fin;
		end else begin
			y_clamp = (div_rsp.quotient <= 0) ? 8'd0
				: (div_rsp.quotient >= 255) ? 8'd255 : div_rsp.quotient[7:0];
			y_fin = negate_q ? 8'd255 - y_clamp : y_clamp;
		end
	end

	// Median running count.
	logic [CUM_W-1:0] cum_next;
	assign cum_next = cum_q + CUM_W'(hist_rdata);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METH_SUM;
			low_q    <= '0;
			high_q   <= CFG_W'(255);
			scale_q  <= CFG_W'(255);
			negate_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_METHOD: method_q <= cfg_data[1:0];
				REG_LOW:    low_q    <= cfg_data;
				REG_HIGH:   high_q   <= cfg_data;
				REG_SCALE:  scale_q  <= cfg_data;
				REG_NEGATE: negate_q <= cfg_data[0];
				default:    method_q <= method_q;
			endcase
		end
	end

	// Sequencer and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// The result word is raised when one is done and dropped once taken.
			if (state_q == S_DONE && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						pix_q    <= pixel_index;
						chroma_q <= is_chroma;
						ns_q     <= new_sample;
						os_q     <= old_sample;
						frames_q <= frames_stacked;
						fwd_q    <= drop_old && !(cmd == CMD_ACC && method_q == METH_MED);
						bin_q    <= '0;
						cum_q    <= '0;
						priority case (1'b1)
							cmd == CMD_CLEAR: state_q <= S_CLR;
							cmd == CMD_ACC && method_q == METH_MED:
								state_q <= drop_old ? S_HO_WR : S_HN_WR;
							cmd == CMD_ACC: state_q <= S_ACC_WR;
							cmd == CMD_READ: state_q <= S_RD_WAIT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CLR: begin
					bin_q <= bin_q + 1'b1;
					if (bin_q == FINAL_BIN) state_q <= S_IDLE;
				end
				S_ACC_WR: state_q <= S_IDLE;
				S_HO_WR: begin
					dec_q   <= hist_rdata - 1'b1;
					fwd_q   <= (ns_q == os_q);
					state_q <= S_HN_WR;
				end
				S_HN_WR: state_q <= S_IDLE;
				S_RD_WAIT: begin
					priority if (method_q == METH_MED && frames_q <= 9'd2) begin
						vres_q  <= 1'b0;
						y_q     <= 8'd0;
						state_q <= S_DONE;
					end else if (method_q == METH_MED) begin
						vres_q  <= 1'b1;
						y_q     <= 8'd255;
						state_q <= S_MED_RD;
					end else if (method_q == METH_AVG && frames_q == '0) begin
						vres_q  <= 1'b1;
						y_q     <= 8'd255;
						state_q <= S_DONE;
					end else begin
						vres_q  <= 1'b1;
						y_q     <= 8'd255;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						y_q     <= y_fin;
						state_q <= S_DONE;
					end
				end
				S_MED_RD: state_q <= S_MED_CHK;
				S_MED_CHK: begin
					cum_q <= cum_next;
					if (cum_next > CUM_W'(frames_q[8:1])) begin
						y_q     <= bin_q;
						state_q <= S_DONE;
					end else if (bin_q == LAST_BIN) begin
						y_q     <= 8'd255;
						state_q <= S_DONE;
					end else begin
						bin_q   <= bin_q + 1'b1;
						state_q <= S_MED_RD;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_pixel_q <= y_q;
						valid_res_q <= vres_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign out_pixel = out_pixel_q;
	assign valid_res = valid_res_q;

endmodule

FILE: rtl/fsa_ram.sv
// Generic simple dual-port RAM with registered read data.
module fsa_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 18
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/fsa_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module fsa_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  fsa_pkg::div_req_t req,
	output fsa_pkg::div_rsp_t rsp
);
	import fsa_pkg::*;

	localparam int CNT_BITS = $clog2(MAG_W + 1);

	logic [MAG_W-1:0]    quo_q;
	logic [DIVS_W-1:0]   rem_q;
	logic [DIVS_W-1:0]   div_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                neg_q;
	logic                done_q;
	logic [DIVD_W-1:0]   mag;
	logic [DIVS_W:0]     trial;
	logic                fits;

	// Magnitude of the dividend and one restoring step.
	assign mag   = req.dividend[DIVD_W-1] ? DIVD_W'(-req.dividend) : req.dividend;
	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the shift-subtract loop.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= mag[MAG_W-1:0];
			rem_q <= '0;
			div_q <= req.divisor;
			neg_q <= req.dividend[DIVD_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? DIVS_W'(trial - {1'b0, div_q}) : trial[DIVS_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

FILE: rtl/fsa_checker.sv
// Port-level checks of the frame stack accumulator and their binding.
module fsa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic [1:0] cmd,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_pixel,
	input logic       valid_res
);
	import fsa_pkg::*;

	// A stalled result word holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_pixel) && $stable(valid_res))
		else $error("result word changed while stalled");

	// An invalid result always reads as zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> out_pixel == 8'd0)
		else $error("invalid result is not zero");

	// Any real command leaves the block busy once it is taken.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && cmd != CMD_NOP |=> !item_ready)
		else $error("word taken in the cycle after a command");

	// A fresh result never appears in the cycle right after a word is taken.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !res_valid |=> !res_valid)
		else $error("result appeared too early");

endmodule

bind frame_stack_accumulator fsa_checker u_fsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.out_pixel (out_pixel),
	.valid_res (valid_res)
);

FILE: bench/tb_frame_stack_accumulator.sv
// Self-checking testbench of the frame stack accumulator: directed and random words.
`timescale 1ns / 100ps

module tb_frame_stack_accumulator;
	import fsa_pkg::*;

	localparam int IDLE_LIMIT = 1000000;
	localparam int SETTLE     = 600;

	typedef struct {
		cmd_t       op;
		logic [9:0] pix;
		logic       chroma;
		logic [7:0] ns;
		logic [7:0] os;
		logic       drop;
		logic [8:0] frames;
	} word_t;

	typedef struct {
		logic [7:0] pix_val;
		logic       ok;
	} pixel_out_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic item_valid;
	logic item_ready;
	logic [1:0] cmd;
	logic [PIX_W-1:0] pixel_index;
	logic is_chroma;
	logic [7:0] new_sample;
	logic [7:0] old_sample;
	logic drop_old;
	logic [8:0] frames_stacked;
	logic res_valid;
	logic res_ready;
	logic [7:0] out_pixel;
	logic valid_res;

	// Shadow of the block's registers and memories.
	logic [1:0]  sh_method;
	logic [15:0] sh_low;
	logic [15:0] sh_high;
	logic [15:0] sh_scale;
	logic        sh_negate;
	logic [17:0] sum_mem [0:PIXELS-1];
	logic [8:0]  hist_mem [0:PIXELS*BINS-1];

	pixel_out_t pending_pixels[$];
	int mismatches;
	int idle_cycles;
	int hold_req;
	int rx_gap;
	bit rx_stall_on;
	bit tx_gaps_on;

	frame_stack_accumulator uut (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [7:0] clamp_byte(longint v);
		if (v <= 0) return 8'd0;
		if (v >= 255) return 8'd255;
		return v[7:0];
	endfunction

	// Updates the shadow state for one accepted word and queues the pixel it yields.
	function automatic void predict_pixel(word_t w);
		logic [17:0] a;
		logic [17:0] bias;
		longint s;
		longint v;
		longint d;
		longint span;
		int base;
		int cum;
		int lim;
		pixel_out_t r;
		base = int'(w.pix) * BINS;
		case (w.op)
			CMD_CLEAR: begin
				sum_mem[w.pix] = '0;
				for (int b = 0; b < BINS; b++) hist_mem[base + b] = '0;
			end
			CMD_ACC: begin
				if (sh_method == METH_MED) begin
					if (w.drop) hist_mem[base + w.os] = hist_mem[base + w.os] - 9'd1;
					hist_mem[base + w.ns] = hist_mem[base + w.ns] + 9'd1;
				end else begin
					a = sum_mem[w.pix];
					bias = w.chroma ? 18'd128 : 18'd0;
					if (w.drop) a = a - {10'd0, w.os} + bias;
					a = a + {10'd0, w.ns} - bias;
					sum_mem[w.pix] = a;
				end
			end
			CMD_READ: begin
				s = longint'($signed(sum_mem[w.pix]));
				r.ok = 1'b1;
				if (sh_method == METH_AVG) begin
					if (w.frames == 0) r.pix_val = 8'd255;
					else r.pix_val = clamp_byte(s / longint'(w.frames) + (w.chroma ? 128 : 0));
				end else if (sh_method == METH_MED) begin
					if (w.frames <= 2) begin
						r.ok = 1'b0;
						r.pix_val = 8'd0;
					end else begin
						lim = int'(w.frames) / 2;
						cum = 0;
						r.pix_val = 8'd255;
						for (int b = 0; b < BINS - 1; b++) begin
							cum += hist_mem[base + b];
							if (cum > lim) begin
								r.pix_val = b[7:0];
								break;
							end
						end
					end
				end else if (w.chroma) begin
					d = (sh_scale == 0) ? 1 : longint'(sh_scale);
					v = (s * 128) / d;
					if (v <= -128) r.pix_val = 8'd0;
					else if (v >= 127) r.pix_val = 8'd255;
					else r.pix_val = v[7:0] + 8'd128;
				end else begin
					span = longint'(sh_high) - longint'(sh_low);
					if (span <= 0) span = 1;
					r.pix_val = clamp_byte(((s - longint'(sh_low)) * 255) / span);
					if (sh_negate) r.pix_val = 8'd255 - r.pix_val;
				end
				pending_pixels.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// Offers one word and waits until the block takes it.
	task automatic send_word(word_t w);
		int gap;
		item_valid <= 1'b1;
		cmd <= w.op;
		pixel_index <= w.pix;
		is_chroma <= w.chroma;
		new_sample <= w.ns;
		old_sample <= w.os;
		drop_old <= w.drop;
		frames_stacked <= w.frames;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predict_pixel(w);
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic make_word(cmd_t op, int pix, bit chroma, int ns, int os, bit drop, int frames);
		word_t w;
		w.op = op;
		w.pix = pix[9:0];
		w.chroma = chroma;
		w.ns = ns[7:0];
		w.os = os[7:0];
		w.drop = drop;
		w.frames = frames[8:0];
		send_word(w);
	endtask

	// Waits until every pixel has come out and any clear still running is done.
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_METHOD: sh_method = data[1:0];
			REG_LOW:    sh_low = data;
			REG_HIGH:   sh_high = data;
			REG_SCALE:  sh_scale = data;
			REG_NEGATE: sh_negate = data[0];
			default: ;
		endcase
	endtask

	task automatic set_config(int meth, int low, int high, int scale, bit neg);
		wait_drained();
		write_reg(REG_METHOD, meth[15:0]);
		write_reg(REG_LOW, low[15:0]);
		write_reg(REG_HIGH, high[15:0]);
		write_reg(REG_SCALE, scale[15:0]);
		write_reg(REG_NEGATE, {15'd0, neg});
	endtask

	// Sum mode: stretch extremes, negate, chroma scaling and an ignored command.
	task automatic test_sum_readout();
		set_config(METH_SUM, 0, 255, 255, 1'b0);
		make_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		make_word(CMD_ACC, 0, 0, 255, 0, 0, 0);
		make_word(CMD_READ, 0, 0, 0, 0, 0, 0);
		make_word(CMD_ACC, 1023, 1, 0, 0, 0, 0);
		make_word(CMD_ACC, 1023, 1, 255, 255, 1, 0);
		make_word(CMD_READ, 1023, 1, 0, 0, 0, 0);
		make_word(CMD_NOP, 0, 1, 255, 255, 1, 511);
		make_word(CMD_READ, 0, 1, 0, 0, 0, 0);
		set_config(METH_SUM, 65280, 0, 0, 1'b1);
		make_word(CMD_READ, 0, 0, 0, 0, 0, 0);
		make_word(CMD_READ, 1023, 1, 0, 0, 0, 0);
		set_config(3, 100, 65280, 65535, 1'b1);
		make_word(CMD_ACC, 0, 0, 200, 0, 0, 0);
		make_word(CMD_READ, 0, 0, 0, 0, 0, 0);
		make_word(CMD_READ, 1023, 1, 0, 0, 0, 0);
		make_word(CMD_CLEAR, 1023, 0, 0, 0, 0, 0);
		make_word(CMD_READ, 1023, 1, 0, 0, 0, 0);
	endtask

	// Average mode: zero frames, chroma bias and clamping.
	task automatic test_average_readout();
		set_config(METH_AVG, 0, 255, 255, 1'b0);
		make_word(CMD_ACC, 3, 1, 0, 0, 0, 0);
		make_word(CMD_READ, 3, 1, 0, 0, 0, 0);
		make_word(CMD_READ, 3, 1, 0, 0, 0, 1);
		make_word(CMD_READ, 3, 0, 0, 0, 0, 1);
		make_word(CMD_READ, 0, 0, 0, 0, 0, 511);
		make_word(CMD_READ, 0, 0, 0, 0, 0, 256);
	endtask

	// Median mode: few frames, bin walk to the last bin, wrapped counts.
	task automatic test_median_readout();
		set_config(METH_MED, 0, 255, 255, 1'b0);
		make_word(CMD_CLEAR, 9, 0, 0, 0, 0, 0);
		make_word(CMD_ACC, 9, 0, 10, 0, 0, 0);
		make_word(CMD_ACC, 9, 0, 20, 0, 0, 0);
		make_word(CMD_READ, 9, 0, 0, 0, 0, 2);
		make_word(CMD_ACC, 9, 0, 255, 0, 0, 0);
		make_word(CMD_READ, 9, 0, 0, 0, 0, 3);
		make_word(CMD_ACC, 9, 0, 255, 10, 1, 0);
		make_word(CMD_READ, 9, 0, 0, 0, 0, 3);
		make_word(CMD_ACC, 9, 0, 0, 7, 1, 0);
		make_word(CMD_READ, 9, 0, 0, 0, 0, 511);
		make_word(CMD_READ, 9, 1, 0, 0, 0, 4);
	endtask

	// Drives one sum past the signed range of its 18-bit width.
	task automatic test_sum_wrap();
		set_config(METH_SUM, 0, 65280, 255, 1'b0);
		tx_gaps_on = 1'b0;
		make_word(CMD_CLEAR, 77, 0, 0, 0, 0, 0);
		for (int i = 0; i < 520; i++) begin
			make_word(CMD_ACC, 77, 0, 255, 0, 0, 0);
			if (i % 130 == 129 || i >= 512) make_word(CMD_READ, 77, 0, 0, 0, 0, 0);
		end
		tx_gaps_on = 1'b1;
	endtask

	// The receiver stops for a long stretch while reads keep coming.
	task automatic test_backpressure();
		set_config(METH_AVG, 0, 255, 255, 1'b0);
		hold_req = 400;
		tx_gaps_on = 1'b0;
		for (int i = 0; i < 30; i++) make_word(CMD_READ, $urandom_range(0, 1023), i[0], 0, 0, 0, i);
		tx_gaps_on = 1'b1;
	endtask

	// Random phases: sliding windows on a few pixels, with noise words mixed in.
	task automatic test_random_mix();
		int pool [8];
		bit pool_chroma [8];
		int win_size [8];
		logic [7:0] window [8][$];
		int slot;
		int r;
		int frames;
		logic [7:0] smp;
		logic [7:0] old;
		bit full;
		word_t w;
		for (int ph = 0; ph < 10; ph++) begin
			r = $urandom_range(0, 9);
			case (ph)
				0: set_config(METH_MED, 0, 255, 255, 1'b0);
				1: set_config(METH_SUM, 0, 65280, 1, 1'b1);
				2: set_config(METH_AVG, 0, 0, 0, 1'b0);
				default: set_config(r < 3 ? METH_MED : (r < 9 ? $urandom_range(0, 1) : 3),
					$urandom_range(0, 2000), $urandom_range(0, 65535),
					$urandom_range(0, 65535) >> $urandom_range(0, 15), 1'($urandom_range(0, 1)));
			endcase
			rx_stall_on = (ph != 4);
			tx_gaps_on = (ph != 5);
			for (int k = 0; k < 8; k++) begin
				pool[k] = $urandom_range(0, 1023);
				pool_chroma[k] = 1'($urandom_range(0, 1));
				win_size[k] = $urandom_range(3, 12);
				window[k].delete();
				make_word(CMD_CLEAR, pool[k], 0, 0, 0, 0, 0);
			end
			for (int i = 0; i < 75; i++) begin
				slot = $urandom_range(0, 7);
				r = $urandom_range(0, 99);
				if (r < 10) begin
					w.op = cmd_t'($urandom_range(0, 3));
					if (w.op == CMD_CLEAR && $urandom_range(0, 3) != 0) w.op = CMD_READ;
					w.pix = (r < 5) ? pool[slot][9:0] : 10'($urandom_range(0, 1023));
					w.chroma = 1'($urandom_range(0, 1));
					w.ns = 8'($urandom_range(0, 255));
					w.os = 8'($urandom_range(0, 255));
					w.drop = 1'($urandom_range(0, 1));
					w.frames = 9'($urandom_range(0, 511));
					send_word(w);
				end else if (r < 78) begin
					smp = 8'($urandom_range(0, 255));
					full = (window[slot].size() >= win_size[slot]);
					old = full ? window[slot].pop_front() : 8'($urandom_range(0, 255));
					window[slot].push_back(smp);
					make_word(CMD_ACC, pool[slot], pool_chroma[slot], smp, old, full, 0);
				end else if (r < 98) begin
					frames = window[slot].size();
					if ($urandom_range(0, 7) == 0) frames = $urandom_range(0, 511);
					make_word(CMD_READ, pool[slot], pool_chroma[slot], 0, 0, 0, frames);
				end else begin
					window[slot].delete();
					make_word(CMD_CLEAR, pool[slot], 0, 0, 0, 0, 0);
				end
			end
		end
		rx_stall_on = 1'b1;
		tx_gaps_on = 1'b1;
	endtask

	// Receiver side of the result channel.
	initial begin
		res_ready = 1'b0;
		rx_gap = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				res_ready <= 1'b0;
				hold_req--;
			end else if (rx_gap > 0) begin
				res_ready <= 1'b0;
				rx_gap--;
			end else begin
				res_ready <= 1'b1;
				if (rx_stall_on && $urandom_range(0, 7) == 0) rx_gap = pick_gap();
			end
		end
	end

	// Each result word is compared with the oldest expected pixel.
	always @(posedge clk) begin
		pixel_out_t e;
		if (arst_n && res_valid && res_ready) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: out_pixel %0d valid_res %0d",
						out_pixel, valid_res);
			end else begin
				e = pending_pixels.pop_front();
				if (out_pixel !== e.pix_val || valid_res !== e.ok) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result word: expected %0d/%0d, got %0d/%0d",
							e.pix_val, e.ok, out_pixel, valid_res);
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("frame_stack_accumulator: mismatch");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		cmd = '0;
		pixel_index = '0;
		is_chroma = 1'b0;
		new_sample = '0;
		old_sample = '0;
		drop_old = 1'b0;
		frames_stacked = '0;
		mismatches = 0;
		idle_cycles = 0;
		hold_req = 0;
		rx_stall_on = 1'b1;
		tx_gaps_on = 1'b1;
		sh_method = METH_SUM;
		sh_low = 16'd0;
		sh_high = 16'd255;
		sh_scale = 16'd255;
		sh_negate = 1'b0;
		for (int i = 0; i < PIXELS; i++) sum_mem[i] = '0;
		for (int i = 0; i < PIXELS * BINS; i++) hist_mem[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sum_readout();
		test_average_readout();
		test_median_readout();
		test_sum_wrap();
		test_backpressure();
		test_random_mix();
		wait_drained();
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("frame_stack_accumulator: match");
		else
			$display("frame_stack_accumulator: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fsa_pkg.sv
rtl/fsa_ram.sv
rtl/fsa_divider.sv
rtl/frame_stack_accumulator.sv
rtl/fsa_checker.sv
bench/tb_frame_stack_accumulator.sv
